FILE: hdl/utf8_stream_sanitizer_assert.svh
// Assertion macros for the UTF-8 stream sanitiser.
// Depends on nothing; included by the files that carry concurrent assertions.
`ifndef UTF8_STREAM_SANITIZER_ASSERT_SVH
`define UTF8_STREAM_SANITIZER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define U8SAN_CHECK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define U8SAN_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/u8san_pkg.sv
// Shared types and constants for the UTF-8 stream sanitiser.
// Depends on nothing; imported by the decoder and the top level.
package u8san_pkg;

  localparam int MAX_GROUP  = 4;
  localparam int FIFO_DEPTH = 8;

  localparam logic [7:0]  QMARK   = 8'h3F;
  localparam logic [7:0]  SPACE   = 8'h20;
  localparam logic [7:0]  TAB     = 8'h09;
  localparam logic [7:0]  DEL     = 8'h7F;
  localparam logic [20:0] CP_MAX  = 21'h10FFFF;

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  // Bytes produced by one input transaction, in order, and how many are used.
  typedef struct packed {
    logic [0:3][7:0] bytes;
    logic [2:0]      count;
    logic            last;
  } u8san_group_t;

endpackage

FILE: hdl/u8san_stream_if.sv
// Valid/ready stream interfaces for the input and output of the sanitiser.
// Depends on nothing.
interface u8san_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface u8san_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: hdl/u8san_decode.sv
// Sequence tracker and per-byte decoder of the UTF-8 stream sanitiser.
// Depends on u8san_pkg.
module u8san_decode import u8san_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   in_byte,
  input  logic         in_last,
  output u8san_group_t grp,
  output logic         seq_open
);

  logic [7:0]       held_lead, held_lead_next;
  logic [0:1][7:0]  held_continuations;
  logic [1:0]       held_count, held_count_next;
  logic [2:0]       expected_length, expected_length_next;
  logic [20:0]      code_point_acc, code_point_acc_next;

  logic        store_cont;
  logic        is_cont;
  logic [2:0]  fresh_len;
  logic [20:0] fresh_bits;
  logic        fresh_emit;
  logic        fresh_start;
  logic [7:0]  fresh_val;
  logic [2:0]  total;
  logic [20:0] acc_join;
  logic [1:0]  fresh_slot;

  // Classification of the byte as though no sequence were open.
  always_comb begin
    fresh_len  = LEN_NONE;
    fresh_bits = '0;
    if ((in_byte & LEAD2_MASK) == LEAD2_CODE) begin
      fresh_len  = LEN_2;
      fresh_bits = {16'd0, in_byte[4:0]};
    end else if ((in_byte & LEAD3_MASK) == LEAD3_CODE) begin
      fresh_len  = LEN_3;
      fresh_bits = {17'd0, in_byte[3:0]};
    end else if ((in_byte & LEAD4_MASK) == LEAD4_CODE) begin
      fresh_len  = LEN_4;
      fresh_bits = {18'd0, in_byte[2:0]};
    end
  end

  assign fresh_start = in_byte[7] && (fresh_len != LEN_NONE) && !in_last;
  assign fresh_emit  = !fresh_start;

  always_comb begin
    if (in_byte[7]) begin
      fresh_val = QMARK;
    end else if ((in_byte < SPACE && in_byte != TAB) || in_byte == DEL) begin
      fresh_val = SPACE;
    end else begin
      fresh_val = in_byte;
    end
  end

  assign is_cont    = (in_byte[7:6] == 2'b10);
  assign total      = {1'b0, held_count} + 3'd2;
  assign acc_join   = {code_point_acc[14:0], in_byte[5:0]};
  assign fresh_slot = held_count + 2'd1;
  assign seq_open   = (expected_length != LEN_NONE);

  always_comb begin
    grp.bytes            = {MAX_GROUP{QMARK}};
    grp.count            = 3'd0;
    grp.last             = in_last;
    held_lead_next       = held_lead;
    held_count_next      = held_count;
    expected_length_next = expected_length;
    code_point_acc_next  = code_point_acc;
    store_cont           = 1'b0;

    if (expected_length == LEN_NONE) begin
      grp.bytes[0] = fresh_val;
      grp.count    = {2'd0, fresh_emit};
      if (fresh_start) begin
        held_lead_next       = in_byte;
        held_count_next      = 2'd0;
        expected_length_next = fresh_len;
        code_point_acc_next  = fresh_bits;
      end
    end else if (is_cont) begin
      code_point_acc_next = acc_join;
      if (total >= expected_length) begin
        // Sequence complete: pass it through, or mark every byte if too large.
        if (acc_join <= CP_MAX) begin
          grp.bytes[0] = held_lead;
          grp.bytes[1] = (held_count == 2'd0) ? in_byte : held_continuations[0];
          grp.bytes[2] = (held_count == 2'd1) ? in_byte : held_continuations[1];
          grp.bytes[3] = in_byte;
        end
        grp.count            = total;
        held_lead_next       = '0;
        held_count_next      = 2'd0;
        expected_length_next = LEN_NONE;
        code_point_acc_next  = '0;
      end else if (in_last) begin
        grp.count = total;
      end else begin
        store_cont      = 1'b1;
        held_count_next = held_count + 2'd1;
      end
    end else begin
      // Broken sequence: mark the lead and held bytes, then treat this byte afresh.
      grp.bytes[fresh_slot] = fresh_val;
      grp.count             = {1'b0, fresh_slot} + {2'd0, fresh_emit};
      held_lead_next        = '0;
      held_count_next       = 2'd0;
      expected_length_next  = LEN_NONE;
      code_point_acc_next   = '0;
      if (fresh_start) begin
        held_lead_next       = in_byte;
        expected_length_next = fresh_len;
        code_point_acc_next  = fresh_bits;
      end
    end

    if (in_last) begin
      held_lead_next       = '0;
      held_count_next      = 2'd0;
      expected_length_next = LEN_NONE;
      code_point_acc_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_lead       <= '0;
      held_count      <= 2'd0;
      expected_length <= LEN_NONE;
      code_point_acc  <= '0;
    end else if (step) begin
      held_lead       <= held_lead_next;
      held_count      <= held_count_next;
      expected_length <= expected_length_next;
      code_point_acc  <= code_point_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && store_cont) begin
      held_continuations[held_count[0]] <= in_byte;
    end
  end

endmodule

FILE: hdl/utf8_stream_sanitizer.sv
// Top level of the UTF-8 stream sanitiser: input register, decoder and output queue.
// Depends on u8san_pkg, u8san_stream_if, u8san_decode and the assertion header.
//
//   channel   | role   | payload             | accepted when
//   ----------+--------+---------------------+------------------------------
//   in_ch     | sink   | in_byte, in_last    | in_ch.valid && in_ch.ready
//   out_ch    | source | out_byte, out_last  | out_ch.valid && out_ch.ready
//
// One transaction is taken per cycle while the output keeps up. A byte is decoded in the
// input register and its results (none to four bytes) are written into the output queue
// when the queue has room; the output is presented from the head of the queue.
// The input register only moves on when the queue has room for a full group of four; a
// stalled output lets the queue fill and then holds off the input. Reset is synchronous
// and empties the queue and the input register and closes any open sequence.
`include "utf8_stream_sanitizer_assert.svh"

module utf8_stream_sanitizer import u8san_pkg::*; #(
  parameter int FifoDepth = FIFO_DEPTH
) (
  input logic        clk,
  input logic        rst,
  u8san_in_if.sink   in_ch,
  u8san_out_if.source out_ch
);

  localparam int PtrW = $clog2(FifoDepth);
  localparam int CntW = $clog2(FifoDepth + 1);

  // Input register: holds one transaction until the decoder can place its results.
  logic       ir_valid;
  logic [7:0] ir_byte;
  logic       ir_last;

  // Output queue of sanitised bytes, each with its end-of-string flag.
  logic [FifoDepth-1:0][8:0] fifo_mem;
  logic [PtrW-1:0]           wp;
  logic [PtrW-1:0]           rp;
  logic [CntW-1:0]           count;

  u8san_group_t grp;
  logic         seq_open;
  logic         step;
  logic         room;
  logic         pop;
  logic         take;

  assign room = (count <= CntW'(FifoDepth - MAX_GROUP));
  assign step = ir_valid && room;
  assign take = in_ch.valid && in_ch.ready;
  assign pop  = out_ch.valid && out_ch.ready;

  // The input register may refill in the same cycle that it hands its byte on.
  assign in_ch.ready = !ir_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (take) begin
      ir_valid <= 1'b1;
    end else if (step) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ir_byte <= in_ch.in_byte;
      ir_last <= in_ch.in_last;
    end
  end

  u8san_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .in_byte  (ir_byte),
    .in_last  (ir_last),
    .grp      (grp),
    .seq_open (seq_open)
  );

  // A group is written in order at consecutive queue slots; only its final
  // byte can carry the end-of-string flag.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_GROUP; i++) begin
      if (step && (3'(i) < grp.count)) begin
        fifo_mem[wp + PtrW'(i)] <= {grp.last && (3'(i) == grp.count - 3'd1),
                                    grp.bytes[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (step) begin
        wp <= wp + PtrW'(grp.count);
      end
      if (pop) begin
        rp <= rp + PtrW'(1);
      end
      count <= count + (step ? CntW'(grp.count) : CntW'(0)) - CntW'(pop);
    end
  end

  assign out_ch.valid    = (count != '0);
  assign out_ch.out_byte = fifo_mem[rp][7:0];
  assign out_ch.out_last = fifo_mem[rp][8];

  // The queue never holds more than its depth.
  `U8SAN_CHECK(a_queue_bound, clk, rst, count <= CntW'(FifoDepth), "output queue overflow")
  // The final byte of a string always yields at least one result.
  `U8SAN_CHECK(a_last_emits, clk, rst, !(step && ir_last) || grp.count != 3'd0, "end of string lost")
  // Nothing stays open across the end of a string.
  `U8SAN_CHECK_NEXT(a_closed_after_last, clk, rst, step && ir_last, !seq_open, "sequence left open")
  // A byte waiting for queue room stays in the input register unchanged.
  `U8SAN_CHECK_NEXT(a_ir_hold, clk, rst, ir_valid && !step, ir_valid && $stable(ir_byte) && $stable(ir_last), "input register dropped")

endmodule
